// File: rtl/utrd_pkg.sv
// ----------------------------------------------------------------------------
// utrd_pkg: shared definitions for the radix digit converter
// Field widths, character constants, base limits and the digit-to-ASCII map.
// ----------------------------------------------------------------------------
package utrd_pkg;

    localparam int VALUE_W      = 64;   // width of the value field
    localparam int BASE_W       = 6;    // width of the base field
    localparam int DIGIT_W      = 6;    // width of one stored remainder
    localparam int CHAR_W       = 7;    // width of an ASCII character
    localparam int COUNT_W      = 7;    // width of the digit count field

    localparam int DEF_VALUE_BITS = 64;
    localparam int DEF_MAX_DIGITS = 64;

    localparam logic [BASE_W-1:0]  BASE_MIN      = 6'd2;
    localparam logic [BASE_W-1:0]  BASE_MAX      = 6'd36;
    localparam logic [DIGIT_W-1:0] DECIMAL_LIMIT = 6'd10;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO     = 7'd48;
    localparam logic [CHAR_W-1:0]  CHAR_A        = 7'd65;

    // Status of the shared divider as seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    // Maps a remainder to its ASCII digit: '0'..'9', then 'A' onward.
    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] d_ext;
        d_ext = CHAR_W'(d);
        if (d < DECIMAL_LIMIT)
        begin
            return d_ext + CHAR_ZERO;
        end
        return d_ext - CHAR_W'(DECIMAL_LIMIT) + CHAR_A;
    endfunction

endpackage

// File: rtl/utrd_ram.sv
// ----------------------------------------------------------------------------
// utrd_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module utrd_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/utrd_divider.sv
// ----------------------------------------------------------------------------
// utrd_divider: bit-serial restoring divider
// Divides a VALUE_BITS dividend by a small base, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module utrd_divider #(
    parameter int VALUE_BITS = utrd_pkg::DEF_VALUE_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [VALUE_BITS-1:0]        dividend,
    input  logic [utrd_pkg::BASE_W-1:0]  divisor,
    output utrd_pkg::div_status_t        status,
    output logic [VALUE_BITS-1:0]        quotient,
    output logic [utrd_pkg::DIGIT_W-1:0] remainder
);
    import utrd_pkg::*;

    localparam int CntW = $clog2(VALUE_BITS);

    logic [VALUE_BITS-1:0] q_reg, q_next;
    logic [DIGIT_W-1:0]    r_reg, r_next;
    logic [CntW-1:0]       cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [DIGIT_W:0]      shifted;
    logic [DIGIT_W:0]      diff;
    logic                  fits;

    // The partial remainder stays below the base, so one extra bit suffices.
    always_comb
    begin
        shifted = {r_reg, q_reg[VALUE_BITS-1]};
        diff    = shifted - (DIGIT_W+1)'(divisor);
        fits    = (shifted >= (DIGIT_W+1)'(divisor));
        r_next  = fits ? diff[DIGIT_W-1:0] : shifted[DIGIT_W-1:0];
        q_next  = {q_reg[VALUE_BITS-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CntW'(VALUE_BITS - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CntW'(1);
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
        end
        else if (busy_reg)
        begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = q_reg;
    assign remainder   = r_reg;

endmodule

// File: rtl/unsigned_to_radix_digits_unit.sv
// ----------------------------------------------------------------------------
// unsigned_to_radix_digits_unit: unsigned integer to ASCII digits in a base
// Each digit takes one division in the shared divider, then the first digit is
// read back from the digit store; digits then leave one per cycle while the
// sink keeps up. A new item is taken only after the last digit of the current
// one has left; the bit-serial divider sets the pace of a conversion.
// Reset: asynchronous, active low; the sequencer returns to idle, the digit store is not cleared.
// ----------------------------------------------------------------------------
module unsigned_to_radix_digits_unit #(
    parameter int VALUE_BITS = utrd_pkg::DEF_VALUE_BITS,
    parameter int MAX_DIGITS = utrd_pkg::DEF_MAX_DIGITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // Input channel
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [utrd_pkg::VALUE_W-1:0] value,
    input  logic [utrd_pkg::BASE_W-1:0]  base,
    // Output channel, one transfer per digit
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [utrd_pkg::CHAR_W-1:0]  digit_char,
    output logic [utrd_pkg::COUNT_W-1:0] digit_count,
    output logic                         last
);
    import utrd_pkg::*;

    localparam int AddrW  = $clog2(MAX_DIGITS);
    localparam int CountW = $clog2(MAX_DIGITS + 1);

    // Sequencer states:
    //   S_IDLE  waits for an input transfer.
    //   S_START launches one division of the remaining value by the base.
    //   S_WAIT  waits for the divider, then stores the remainder as a digit.
    //   S_READ  fetches the most significant digit from the digit store.
    //   S_SHOW  presents a digit; each output transfer fetches the next one,
    //           so digits leave back to back while the sink keeps up.
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_START = 5'b00010,
        S_WAIT  = 5'b00100,
        S_READ  = 5'b01000,
        S_SHOW  = 5'b10000
    } state_t;

    state_t                state_reg, state_next;
    logic [VALUE_BITS-1:0] remaining_value_reg;
    logic [BASE_W-1:0]     base_reg;
    logic [CountW-1:0]     digits_found_reg, digits_found_next;
    logic [AddrW-1:0]      emit_idx_reg;
    logic [BASE_W-1:0]     base_clamped;

    // Shared divider
    logic                  div_start;
    div_status_t           div_status;
    logic [VALUE_BITS-1:0] div_quotient;
    logic [DIGIT_W-1:0]    div_remainder;

    // Digit store
    logic                  ram_we;
    logic                  ram_re;
    logic [AddrW-1:0]      ram_raddr;
    logic [DIGIT_W-1:0]    ram_rdata;

    logic                  in_xfer;
    logic                  out_xfer;
    logic                  conv_done;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;

    // Bases below two act as two, bases above thirty-six act as thirty-six.
    always_comb
    begin
        if (base < BASE_MIN)
        begin
            base_clamped = BASE_MIN;
        end
        else if (base > BASE_MAX)
        begin
            base_clamped = BASE_MAX;
        end
        else
        begin
            base_clamped = base;
        end
    end

    assign digits_found_next = digits_found_reg + CountW'(1);

    // The conversion ends when the quotient reaches zero, or when the store
    // is full, in which case only the low-order digits are kept.
    assign conv_done = (div_quotient == '0) ||
                       (digits_found_next == CountW'(MAX_DIGITS));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (div_status.done)
                begin
                    state_next = conv_done ? S_READ : S_START;
                end
            end
            S_READ:
            begin
                state_next = S_SHOW;
            end
            S_SHOW:
            begin
                if (out_ready && last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= S_IDLE;
            digits_found_reg    <= '0;
            remaining_value_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_xfer)
            begin
                remaining_value_reg <= value[VALUE_BITS-1:0];
                digits_found_reg    <= '0;
            end
            else if (state_reg == S_WAIT && div_status.done)
            begin
                remaining_value_reg <= div_quotient;
                digits_found_reg    <= digits_found_next;
            end
        end
    end

    // Payload registers: base held for the whole conversion, and the store
    // address of the digit currently shown.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            base_reg <= base_clamped;
        end
        if (state_reg == S_WAIT && div_status.done)
        begin
            emit_idx_reg <= digits_found_reg[AddrW-1:0];
        end
        else if (out_xfer && !last)
        begin
            emit_idx_reg <= emit_idx_reg - AddrW'(1);
        end
    end

    assign div_start = (state_reg == S_START);

    utrd_divider #(
        .VALUE_BITS (VALUE_BITS)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (remaining_value_reg),
        .divisor   (base_reg),
        .status    (div_status),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    // Remainders go in least significant first; the read side walks the
    // addresses downward so the most significant digit leaves first.
    assign ram_we = (state_reg == S_WAIT) && div_status.done;

    always_comb
    begin
        ram_re    = 1'b0;
        ram_raddr = emit_idx_reg;
        if (state_reg == S_READ)
        begin
            ram_re = 1'b1;
        end
        else if (out_xfer && !last)
        begin
            ram_re    = 1'b1;
            ram_raddr = emit_idx_reg - AddrW'(1);
        end
    end

    utrd_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (MAX_DIGITS)
    ) u_digit_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (digits_found_reg[AddrW-1:0]),
        .wdata (div_remainder),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = (state_reg == S_SHOW);
    assign digit_char  = digit_to_ascii(ram_rdata);
    assign digit_count = COUNT_W'(digits_found_reg);
    assign last        = (emit_idx_reg == '0);

`ifndef SYNTHESIS
    // The block never takes an item while a digit is on offer.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input accepted while a digit is pending");

    // A division is only launched on an idle divider.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_status.busy)
        else $error("divider restarted while busy");

    // The divider only finishes while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_status.done |-> (state_reg == S_WAIT))
        else $error("divider result arrived outside the wait state");

    // After the final digit leaves, the block is ready for the next item.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_xfer && last) |=> in_ready)
        else $error("block not idle after the final digit");

    // The digit count never exceeds the store depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        digits_found_reg <= CountW'(MAX_DIGITS))
        else $error("digit count beyond store depth");
`endif

endmodule
